>>> rtl/wsd_pkg.sv
// Shared types, codes and helpers for the WebSocket frame deframer.
package wsd_pkg;

    localparam int unsigned LEN_W      = 63;
    localparam int unsigned TDATA_W    = 88;
    localparam int unsigned QUEUE_DEPTH_DEF = 2;

    localparam logic [LEN_W-1:0] MAX_PAYLOAD_RST = LEN_W'(64'd16777216);

    // config register indexes
    localparam logic CFG_SERVER_ROLE = 1'b0;
    localparam logic CFG_MAX_PAYLOAD = 1'b1;

    // result kinds
    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;

    // error codes
    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_RSV      = 3'd1;
    localparam logic [2:0] ERR_OPCODE   = 3'd2;
    localparam logic [2:0] ERR_CONTROL  = 3'd3;
    localparam logic [2:0] ERR_LEN_MSB  = 3'd4;
    localparam logic [2:0] ERR_MASKING  = 3'd5;
    localparam logic [2:0] ERR_SIZE     = 3'd6;

    // 7-bit length codes
    localparam logic [6:0] LEN_CODE_16  = 7'd126;
    localparam logic [6:0] LEN_CODE_64  = 7'd127;
    localparam logic [6:0] CTRL_MAX_LEN = 7'd125;

    // opcodes
    localparam logic [3:0] OP_CONT  = 4'h0;
    localparam logic [3:0] OP_TEXT  = 4'h1;
    localparam logic [3:0] OP_BIN   = 4'h2;
    localparam logic [3:0] OP_CLOSE = 4'h8;
    localparam logic [3:0] OP_PING  = 4'h9;
    localparam logic [3:0] OP_PONG  = 4'hA;

    typedef enum logic [1:0] {
        PH_BASIC,
        PH_EXTLEN,
        PH_MASK,
        PH_PAYLOAD
    } wsd_phase_t;

    typedef struct packed {
        logic             server_role;
        logic [LEN_W-1:0] max_payload;
    } wsd_cfg_t;

    // one classified transaction between parser and output stage
    typedef struct packed {
        logic [1:0]       kind;
        logic [7:0]       data;
        logic [7:0]       key;
        logic             fin;
        logic             rsv1;
        logic [3:0]       opcode;
        logic             masked;
        logic [LEN_W-1:0] length;
        logic             last;
        logic [2:0]       err;
    } wsd_item_t;

    function automatic logic opcode_known(input logic [3:0] op);
        opcode_known = (op == OP_CONT) || (op == OP_TEXT) || (op == OP_BIN) ||
                       (op == OP_CLOSE) || (op == OP_PING) || (op == OP_PONG);
    endfunction

endpackage

>>> rtl/wsd_front.sv
// Header parser: accepts bytes, validates the frame header, classifies each transaction.
module wsd_front import wsd_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  wsd_cfg_t  cfg,
    input  logic      in_valid,
    output logic      in_ready,
    input  logic [7:0] in_byte,
    output logic      push,
    output wsd_item_t push_item,
    input  logic      q_full
);

    wsd_phase_t       phase_reg, phase_next;
    logic [2:0]       hcnt_reg, hcnt_next;
    logic             fin_reg, fin_next;
    logic             rsv1_reg, rsv1_next;
    logic             rsv_high_reg, rsv_high_next;
    logic [3:0]       opcode_reg, opcode_next;
    logic             masked_reg, masked_next;
    logic [6:0]       len_code_reg, len_code_next;
    logic [63:0]      flen_reg, flen_next;
    logic [LEN_W-1:0] rem_reg, rem_next;
    logic [31:0]      key_reg, key_next;
    logic [1:0]       kidx_reg, kidx_next;
    logic             err_reg, err_next;

    logic             run;
    logic             in_basic, in_ext, in_mask, in_payload;
    logic             first, second;
    logic [2:0]       hdr_code;
    logic             short_len;
    logic [63:0]      flen_shift;
    logic             need8, ext_done, len_msb_err;
    logic             len_known;
    logic [LEN_W-1:0] len_val, fin_len;
    logic             cur_masked;
    logic             key_done;
    logic             finish;
    logic [2:0]       fin_code;
    logic             fin_to_payload;
    logic             pay_last;
    logic [7:0]       key_byte;
    logic             err_ev;
    logic [2:0]       err_ev_code;

    assign in_ready   = !q_full;
    assign run        = in_valid && in_ready && !err_reg;

    assign in_basic   = (phase_reg == PH_BASIC);
    assign in_ext     = (phase_reg == PH_EXTLEN);
    assign in_mask    = (phase_reg == PH_MASK);
    assign in_payload = (phase_reg == PH_PAYLOAD);
    assign first      = in_basic && !hcnt_reg[0];
    assign second     = in_basic && hcnt_reg[0];

    // checks on the second header byte, in priority order
    always_comb begin
        if (rsv_high_reg)
            hdr_code = ERR_RSV;
        else if (!opcode_known(opcode_reg))
            hdr_code = ERR_OPCODE;
        else if (opcode_reg[3] && (!fin_reg || (in_byte[6:0] > CTRL_MAX_LEN) || rsv1_reg))
            hdr_code = ERR_CONTROL;
        else
            hdr_code = ERR_NONE;
    end

    assign short_len   = (in_byte[6:0] < LEN_CODE_16);
    assign flen_shift  = {flen_reg[55:0], in_byte};
    assign need8       = (len_code_reg == LEN_CODE_64);
    assign ext_done    = need8 ? (hcnt_reg == 3'd7) : (hcnt_reg == 3'd1);
    assign len_msb_err = ext_done && need8 && flen_shift[63];

    assign len_known = (second && (hdr_code == ERR_NONE) && short_len) ||
                       (in_ext && ext_done && !len_msb_err);
    assign len_val    = second ? {56'd0, in_byte[6:0]} : flen_shift[LEN_W-1:0];
    assign cur_masked = second ? in_byte[7] : masked_reg;
    assign key_done   = in_mask && (hcnt_reg == 3'd3);
    assign finish     = (len_known && !cur_masked) || key_done;
    assign fin_len    = key_done ? flen_reg[LEN_W-1:0] : len_val;

    always_comb begin
        if (cfg.server_role != cur_masked)
            fin_code = ERR_MASKING;
        else if (fin_len > cfg.max_payload)
            fin_code = ERR_SIZE;
        else
            fin_code = ERR_NONE;
    end

    assign fin_to_payload = (fin_code == ERR_NONE) && (fin_len != '0);
    assign pay_last       = (rem_reg == LEN_W'(1));

    always_comb begin
        case (kidx_reg)
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
    end

    always_comb begin
        err_ev      = 1'b0;
        err_ev_code = ERR_NONE;
        if (second && (hdr_code != ERR_NONE)) begin
            err_ev      = 1'b1;
            err_ev_code = hdr_code;
        end else if (in_ext && len_msb_err) begin
            err_ev      = 1'b1;
            err_ev_code = ERR_LEN_MSB;
        end else if (finish && (fin_code != ERR_NONE)) begin
            err_ev      = 1'b1;
            err_ev_code = fin_code;
        end
    end

    // next state
    always_comb begin
        phase_next = phase_reg;
        if (run) begin
            case (phase_reg)
                PH_BASIC: begin
                    if (second && (hdr_code == ERR_NONE)) begin
                        if (!short_len)
                            phase_next = PH_EXTLEN;
                        else if (in_byte[7])
                            phase_next = PH_MASK;
                        else if (fin_to_payload)
                            phase_next = PH_PAYLOAD;
                    end
                end
                PH_EXTLEN: begin
                    if (ext_done && !len_msb_err) begin
                        if (masked_reg)
                            phase_next = PH_MASK;
                        else if (fin_to_payload)
                            phase_next = PH_PAYLOAD;
                        else
                            phase_next = PH_BASIC;
                    end
                end
                PH_MASK: begin
                    if (key_done)
                        phase_next = fin_to_payload ? PH_PAYLOAD : PH_BASIC;
                end
                PH_PAYLOAD: begin
                    if (pay_last)
                        phase_next = PH_BASIC;
                end
                default: phase_next = PH_BASIC;
            endcase
        end
    end

    // datapath and transaction outputs
    always_comb begin
        hcnt_next     = hcnt_reg;
        fin_next      = fin_reg;
        rsv1_next     = rsv1_reg;
        rsv_high_next = rsv_high_reg;
        opcode_next   = opcode_reg;
        masked_next   = masked_reg;
        len_code_next = len_code_reg;
        flen_next     = flen_reg;
        rem_next      = rem_reg;
        key_next      = key_reg;
        kidx_next     = kidx_reg;
        err_next      = err_reg || (run && err_ev);
        push          = run && (err_ev || finish || in_payload);
        push_item     = '0;

        if (run) begin
            if (first) begin
                fin_next      = in_byte[7];
                rsv1_next     = in_byte[6];
                rsv_high_next = |in_byte[5:4];
                opcode_next   = in_byte[3:0];
                hcnt_next     = 3'd1;
            end
            if (second) begin
                masked_next   = in_byte[7];
                len_code_next = in_byte[6:0];
                hcnt_next     = 3'd0;
                flen_next     = short_len ? {57'd0, in_byte[6:0]} : 64'd0;
            end
            if (in_ext) begin
                flen_next = flen_shift;
                hcnt_next = ext_done ? 3'd0 : hcnt_reg + 3'd1;
            end
            if (in_mask) begin
                key_next  = {key_reg[23:0], in_byte};
                hcnt_next = key_done ? 3'd0 : hcnt_reg + 3'd1;
            end
            if (finish) begin
                rem_next  = fin_len;
                kidx_next = 2'd0;
            end
            if (in_payload) begin
                rem_next  = rem_reg - LEN_W'(1);
                kidx_next = kidx_reg + 2'd1;
            end
        end

        if (err_ev) begin
            push_item.kind = KIND_ERROR;
            push_item.err  = err_ev_code;
        end else if (finish) begin
            push_item.kind   = KIND_HEADER;
            push_item.fin    = fin_reg;
            push_item.rsv1   = rsv1_reg;
            push_item.opcode = opcode_reg;
            push_item.masked = cur_masked;
            push_item.length = fin_len;
            push_item.last   = (fin_len == '0);
        end else if (in_payload) begin
            push_item.kind   = KIND_PAYLOAD;
            push_item.data   = in_byte;
            push_item.key    = masked_reg ? key_byte : 8'd0;
            push_item.fin    = fin_reg;
            push_item.rsv1   = rsv1_reg;
            push_item.opcode = opcode_reg;
            push_item.masked = masked_reg;
            push_item.length = flen_reg[LEN_W-1:0];
            push_item.last   = pay_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_BASIC;
            hcnt_reg     <= 3'd0;
            fin_reg      <= 1'b0;
            rsv1_reg     <= 1'b0;
            rsv_high_reg <= 1'b0;
            opcode_reg   <= 4'd0;
            masked_reg   <= 1'b0;
            len_code_reg <= 7'd0;
            flen_reg     <= 64'd0;
            rem_reg      <= '0;
            key_reg      <= 32'd0;
            kidx_reg     <= 2'd0;
            err_reg      <= 1'b0;
        end else begin
            phase_reg    <= phase_next;
            hcnt_reg     <= hcnt_next;
            fin_reg      <= fin_next;
            rsv1_reg     <= rsv1_next;
            rsv_high_reg <= rsv_high_next;
            opcode_reg   <= opcode_next;
            masked_reg   <= masked_next;
            len_code_reg <= len_code_next;
            flen_reg     <= flen_next;
            rem_reg      <= rem_next;
            key_reg      <= key_next;
            kidx_reg     <= kidx_next;
            err_reg      <= err_next;
        end
    end

`ifndef SYNTHESIS
    // nothing leaves the parser once an error is latched
    a_quiet_after_error: assert property (@(posedge aclk) disable iff (!aresetn)
        err_reg |-> !push)
        else $error("wsd_front: transaction pushed after latched error");

    // an error transaction always latches the error flag
    a_error_latches: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && (push_item.kind == KIND_ERROR)) |=> err_reg)
        else $error("wsd_front: error pushed without latching");
`endif

endmodule

>>> rtl/wsd_queue.sv
// Short flip-flop queue between the parser and the output stage.
module wsd_queue import wsd_pkg::*; #(
    parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      wr_en,
    input  wsd_item_t wr_item,
    output logic      full,
    input  logic      rd_en,
    output logic      not_empty,
    output wsd_item_t rd_item
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    wsd_item_t        mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign rd_item   = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (rd_en)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (wr_en && !rd_en)
            count_next = count_reg + CNT_W'(1);
        else if (!wr_en && rd_en)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge aclk) begin
        if (wr_en)
            mem_reg[wr_ptr_reg] <= wr_item;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> !full)
        else $error("wsd_queue: write while full");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_en |-> not_empty)
        else $error("wsd_queue: read while empty");
`endif

endmodule

>>> rtl/wsd_back.sv
// Output stage: unmasks payload bytes and holds the result transaction for the sink.
module wsd_back import wsd_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_valid,
    input  wsd_item_t          q_item,
    output logic               q_pop,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,
    output logic [1:0]         m_tuser,
    output logic               m_tlast
);

    logic               valid_reg, valid_next;
    logic [TDATA_W-1:0] tdata_reg, tdata_next;
    logic [1:0]         tuser_reg;
    logic               tlast_reg;

    assign q_pop = q_valid && (!valid_reg || m_tready);

    always_comb begin
        tdata_next = {7'd0, q_item.err, q_item.length, q_item.masked, q_item.opcode,
                      q_item.rsv1, q_item.fin, q_item.data ^ q_item.key};
        if (q_pop)
            valid_next = 1'b1;
        else if (m_tready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            tdata_reg <= tdata_next;
            tuser_reg <= q_item.kind;
            tlast_reg <= q_item.last;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = tdata_reg;
    assign m_tuser  = tuser_reg;
    assign m_tlast  = tlast_reg;

endmodule

>>> rtl/websocket_frame_deframer_unit.sv
// Top level of the WebSocket (RFC 6455) receive-side frame deframer.
// Takes one received byte per transaction and sustains one byte per clock: the parser
// accepts a byte every cycle while its two-entry queue has room, and the output register
// frees a slot each cycle the sink takes a result, so throughput is set by the sink alone.
// A result is written into the queue and then into the output register before it turns valid
// on the m_ side, and it may wait in either while the sink stalls. Header bytes
// produce no result until the header (length, optional extended length, optional mask
// key) is complete; then one header result is sent, followed by one result per payload
// byte, unmasked with key byte (count mod 4); tlast marks the frame's last result,
// including the header of an empty frame. A protocol error yields one error result,
// after which all bytes are accepted and dropped until reset.
// Configuration (cfg_addr 0: server role, 1: max payload length) may be written only
// while the block is idle.
module websocket_frame_deframer_unit import wsd_pkg::*; #(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    // config write port
    input  logic               cfg_wr_en,
    input  logic               cfg_addr,
    input  logic [LEN_W-1:0]   cfg_wdata,
    // received bytes
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,   // [7:0] byte_in
    // results
    output logic               m_tvalid,
    input  logic               m_tready,
    // [7:0] byte_out, [8] fin, [9] rsv1, [13:10] opcode, [14] masked,
    // [77:15] payload_length, [80:78] error_code, [87:81] zero
    output logic [TDATA_W-1:0] m_tdata,
    output logic [1:0]         m_tuser,   // [1:0] kind
    output logic               m_tlast    // last_of_frame
);

    wsd_cfg_t  cfg_reg, cfg_next;
    logic      push;
    wsd_item_t push_item;
    logic      q_full;
    logic      q_pop;
    logic      q_not_empty;
    wsd_item_t q_item;

    // config registers
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_SERVER_ROLE: cfg_next.server_role = cfg_wdata[0];
                CFG_MAX_PAYLOAD: cfg_next.max_payload = cfg_wdata;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.server_role <= 1'b1;
            cfg_reg.max_payload <= MAX_PAYLOAD_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // front: header parse, checks, per-byte classification
    wsd_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_byte   (s_tdata),
        .push      (push),
        .push_item (push_item),
        .q_full    (q_full)
    );

    // decouples parser from a stalled sink
    wsd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .wr_en     (push),
        .wr_item   (push_item),
        .full      (q_full),
        .rd_en     (q_pop),
        .not_empty (q_not_empty),
        .rd_item   (q_item)
    );

    // back: unmask and present result transactions
    wsd_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_not_empty),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

`ifndef SYNTHESIS
    // an error result never closes a frame
    a_error_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == KIND_ERROR)) |-> !m_tlast)
        else $error("deframer: error result marked last");

    // a header that closes its frame carries length zero
    a_empty_header: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == KIND_HEADER) && m_tlast) |-> (m_tdata[77:15] == '0))
        else $error("deframer: last header with nonzero length");
`endif

endmodule

>>> tb/sv/websocket_frame_deframer_checker.sv
// Scoreboard for the WebSocket deframer: predicts each result and compares it with the DUT.
module websocket_frame_deframer_checker import wsd_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic               cfg_addr,
    input  logic [LEN_W-1:0]   cfg_wdata,
    input  logic               s_tvalid,
    input  logic               s_tready,
    input  logic [7:0]         s_tdata,
    input  logic               m_tvalid,
    input  logic               m_tready,
    input  logic [TDATA_W-1:0] m_tdata,
    input  logic [1:0]         m_tuser,
    input  logic               m_tlast,
    output int                 mismatches,
    output int                 outstanding,
    output int                 results_checked
);

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [1:0]       kind;
        logic [7:0]       data;
        logic             fin;
        logic             rsv1;
        logic [3:0]       opcode;
        logic             masked;
        logic [LEN_W-1:0] length;
        logic             last;
        logic [2:0]       err;
    } deframe_result_t;

    deframe_result_t expected_results[$];
    int fail_total = 0;
    int checked_total = 0;

    // register copies
    logic             role;
    logic [LEN_W-1:0] max_len;

    // parser copy
    wsd_phase_t  phase;
    logic [3:0]  hdr_cnt;
    logic        fin_f, rsv1_f, mask_f, rsv_hi, err_latched;
    logic [3:0]  op_f;
    logic [6:0]  len_code;
    logic [63:0] frame_len, byte_cnt;
    logic [31:0] key_word;

    function automatic logic opcode_defined(input logic [3:0] op);
        case (op)
            OP_CONT, OP_TEXT, OP_BIN, OP_CLOSE, OP_PING, OP_PONG: opcode_defined = 1'b1;
            default: opcode_defined = 1'b0;
        endcase
    endfunction

    function automatic string describe(input deframe_result_t r);
        describe = $sformatf(
            "kind=%0d byte=%02h fin=%0d rsv1=%0d op=%0d masked=%0d len=%0d last=%0d err=%0d",
            r.kind, r.data, r.fin, r.rsv1, r.opcode, r.masked, r.length, r.last, r.err);
    endfunction

    task automatic reset_parser();
        role        = 1'b1;
        max_len     = MAX_PAYLOAD_RST;
        phase       = PH_BASIC;
        hdr_cnt     = '0;
        fin_f       = 1'b0;
        rsv1_f      = 1'b0;
        mask_f      = 1'b0;
        rsv_hi      = 1'b0;
        err_latched = 1'b0;
        op_f        = '0;
        len_code    = '0;
        frame_len   = '0;
        byte_cnt    = '0;
        key_word    = '0;
    endtask

    task automatic queue_frame_result(input logic [1:0] kind, input logic [7:0] data,
                                      input logic last);
        deframe_result_t r;
        r.kind   = kind;
        r.data   = data;
        r.fin    = fin_f;
        r.rsv1   = rsv1_f;
        r.opcode = op_f;
        r.masked = mask_f;
        r.length = frame_len[LEN_W-1:0];
        r.last   = last;
        r.err    = ERR_NONE;
        expected_results.push_back(r);
    endtask

    task automatic raise_error(input logic [2:0] code);
        deframe_result_t r;
        r      = '0;
        r.kind = KIND_ERROR;
        r.err  = code;
        expected_results.push_back(r);
        err_latched = 1'b1;
    endtask

    // header fully in: role and size checks, then header result
    task automatic close_header();
        if (role != mask_f) begin
            raise_error(ERR_MASKING);
        end else if (frame_len > {1'b0, max_len}) begin
            raise_error(ERR_SIZE);
        end else begin
            byte_cnt = '0;
            hdr_cnt  = '0;
            queue_frame_result(KIND_HEADER, 8'h00, frame_len == 0);
            phase = (frame_len == 0) ? PH_BASIC : PH_PAYLOAD;
        end
    endtask

    task automatic length_done();
        hdr_cnt = '0;
        if (mask_f) phase = PH_MASK;
        else close_header();
    endtask

    task automatic parse_byte(input logic [7:0] b);
        logic [7:0] v;
        logic       last;
        if (!err_latched) begin
            case (phase)
                PH_BASIC: begin
                    if (hdr_cnt == 0) begin
                        fin_f   = b[7];
                        rsv1_f  = b[6];
                        rsv_hi  = (b[5:4] != 2'b00);
                        op_f    = b[3:0];
                        hdr_cnt = 4'd1;
                    end else begin
                        mask_f   = b[7];
                        len_code = b[6:0];
                        hdr_cnt  = '0;
                        if (rsv_hi)
                            raise_error(ERR_RSV);
                        else if (!opcode_defined(op_f))
                            raise_error(ERR_OPCODE);
                        else if (op_f[3] && (!fin_f || len_code > CTRL_MAX_LEN || rsv1_f))
                            raise_error(ERR_CONTROL);
                        else if (len_code >= LEN_CODE_16) begin
                            frame_len = '0;
                            phase     = PH_EXTLEN;
                        end else begin
                            frame_len = 64'(len_code);
                            length_done();
                        end
                    end
                end
                PH_EXTLEN: begin
                    frame_len = {frame_len[55:0], b};
                    hdr_cnt   = hdr_cnt + 4'd1;
                    if (hdr_cnt == ((len_code == LEN_CODE_16) ? 4'd2 : 4'd8)) begin
                        if (len_code == LEN_CODE_64 && frame_len[63]) begin
                            hdr_cnt = '0;
                            raise_error(ERR_LEN_MSB);
                        end else begin
                            length_done();
                        end
                    end
                end
                PH_MASK: begin
                    key_word = {key_word[23:0], b};
                    hdr_cnt  = hdr_cnt + 4'd1;
                    if (hdr_cnt == 4'd4) close_header();
                end
                default: begin
                    v = b;
                    // first key byte sits in the top bits
                    if (mask_f) v = v ^ key_word[8*(3 - byte_cnt[1:0]) +: 8];
                    byte_cnt = byte_cnt + 64'd1;
                    last     = (byte_cnt >= frame_len);
                    queue_frame_result(KIND_PAYLOAD, v, last);
                    if (last) begin
                        phase   = PH_BASIC;
                        hdr_cnt = '0;
                    end
                end
            endcase
        end
    endtask

    task automatic compare_result();
        deframe_result_t want, got;
        got.kind   = m_tuser;
        got.data   = m_tdata[7:0];
        got.fin    = m_tdata[8];
        got.rsv1   = m_tdata[9];
        got.opcode = m_tdata[13:10];
        got.masked = m_tdata[14];
        got.length = m_tdata[77:15];
        got.err    = m_tdata[80:78];
        got.last   = m_tlast;
        checked_total++;
        if (expected_results.size() == 0) begin
            fail_total++;
            if (fail_total <= REPORT_LIMIT)
                $display("unexpected result %0d: %s", checked_total, describe(got));
        end else begin
            want = expected_results.pop_front();
            if (got.kind !== want.kind || got.data !== want.data || got.fin !== want.fin ||
                got.rsv1 !== want.rsv1 || got.opcode !== want.opcode ||
                got.masked !== want.masked || got.length !== want.length ||
                got.last !== want.last || got.err !== want.err ||
                m_tdata[TDATA_W-1:81] !== '0) begin
                fail_total++;
                if (fail_total <= REPORT_LIMIT) begin
                    $display("result %0d mismatch, expected %s", checked_total, describe(want));
                    $display("  actual %s pad=%0h", describe(got), m_tdata[TDATA_W-1:81]);
                end
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            reset_parser();
            expected_results.delete();
        end else begin
            // results at this edge come from earlier bytes, so compare first
            if (m_tvalid && m_tready) compare_result();
            if (cfg_wr_en) begin
                if (cfg_addr == CFG_SERVER_ROLE) role = cfg_wdata[0];
                else max_len = cfg_wdata;
            end
            if (s_tvalid && s_tready) parse_byte(s_tdata);
        end
        mismatches      <= fail_total;
        outstanding     <= expected_results.size();
        results_checked <= checked_total;
    end

endmodule

>>> tb/sv/websocket_frame_deframer_unit_tb.sv
// Testbench top for the WebSocket deframer: stimulus, flow control, watchdog and verdict.
module websocket_frame_deframer_unit_tb;
    import wsd_pkg::*;

    // length encodings of the second header byte
    localparam int ENC_SHORT = 0;
    localparam int ENC_16    = 1;
    localparam int ENC_64    = 2;

    // idle cycles without any transaction before the run is declared hung
    localparam int STALL_LIMIT   = 1000;
    // margin after draining, before config writes and the end
    localparam int SETTLE_CYCLES = 8;

    logic               aclk;
    logic               aresetn;
    logic               cfg_wr_en;
    logic               cfg_addr;
    logic [LEN_W-1:0]   cfg_wdata;
    logic               s_tvalid;
    logic               s_tready;
    logic [7:0]         s_tdata;
    logic               m_tvalid;
    logic               m_tready;
    logic [TDATA_W-1:0] m_tdata;
    logic [1:0]         m_tuser;
    logic               m_tlast;

    int mismatches, outstanding, results_checked;

    // testbench copy of the registers, used to shape legal frames
    logic             cur_role;
    logic [LEN_W-1:0] cur_max;

    int   bytes_sent   = 0;
    int   frames_sent  = 0;
    int   stall_cycles = 0;
    bit   quiet        = 1'b0;   // no idling on either side when set
    logic [2:0] tail_kind;

    websocket_frame_deframer_unit u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    websocket_frame_deframer_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_addr        (cfg_addr),
        .cfg_wdata       (cfg_wdata),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .m_tlast         (m_tlast),
        .mismatches      (mismatches),
        .outstanding     (outstanding),
        .results_checked (results_checked)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Sink side: random back-pressure bursts, none once quiet.
    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (!quiet && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    // Watchdog: any transaction on either channel restarts the count.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", stall_cycles);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // One byte transaction; valid stays up into the next byte unless a gap is drawn.
    task automatic push_byte(input logic [7:0] b);
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        bytes_sent++;
        if (!quiet && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
    endtask

    // Stop sending until every predicted result has been taken, then settle.
    task automatic wait_drained(input int settle);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (settle) @(posedge aclk);
    endtask

    // Writes both registers on back-to-back cycles; only called with the block idle.
    task automatic write_config(input logic role, input logic [LEN_W-1:0] limit);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= CFG_SERVER_ROLE;
        cfg_wdata <= LEN_W'(role);
        @(posedge aclk);
        cfg_addr  <= CFG_MAX_PAYLOAD;
        cfg_wdata <= limit;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        cur_role = role;
        cur_max  = limit;
    endtask

    // Full frame: header bytes, extended length big-endian, key if masked, npay payload bytes.
    // npay may differ from len to leave a frame open or to stop at a header error.
    task automatic send_frame(input logic [7:0] hdr, input logic mask_on, input int enc,
                              input logic [63:0] len, input int npay);
        logic [31:0] key;
        key = $urandom;
        push_byte(hdr);
        case (enc)
            ENC_16:  push_byte({mask_on, LEN_CODE_16});
            ENC_64:  push_byte({mask_on, LEN_CODE_64});
            default: push_byte({mask_on, len[6:0]});
        endcase
        if (enc == ENC_16)
            for (int i = 1; i >= 0; i--) push_byte(len[8*i +: 8]);
        if (enc == ENC_64)
            for (int i = 7; i >= 0; i--) push_byte(len[8*i +: 8]);
        if (mask_on)
            for (int i = 3; i >= 0; i--) push_byte(key[8*i +: 8]);
        for (int i = 0; i < npay; i++) push_byte(8'($urandom_range(0, 255)));
        frames_sent++;
    endtask

    // Legal frame for the current role and size limit; mostly short payloads.
    task automatic random_frame();
        logic [3:0]  op;
        logic        fin_b, rsv1_b, ctrl;
        logic [63:0] len;
        int          enc, sel;
        ctrl = ($urandom_range(0, 9) < 2);
        if (ctrl) begin
            case ($urandom_range(0, 2))
                0:       op = OP_CLOSE;
                1:       op = OP_PING;
                default: op = OP_PONG;
            endcase
            fin_b  = 1'b1;
            rsv1_b = 1'b0;
        end else begin
            case ($urandom_range(0, 2))
                0:       op = OP_CONT;
                1:       op = OP_TEXT;
                default: op = OP_BIN;
            endcase
            fin_b  = 1'($urandom_range(0, 1));
            rsv1_b = 1'($urandom_range(0, 1));
        end
        sel = $urandom_range(0, 39);
        enc = ENC_SHORT;
        len = 64'($urandom_range(0, 10));
        if (sel == 0) begin
            len = 64'($urandom_range(100, 125));        // long short-form frame
        end else if (!ctrl && sel == 1) begin
            enc = ENC_16;
            len = 64'($urandom_range(126, 300));
        end else if (!ctrl && sel >= 26 && sel < 34) begin
            enc = ENC_16;                               // 16-bit form, small value
            len = 64'($urandom_range(0, 12));
        end else if (!ctrl && sel >= 34) begin
            enc = ENC_64;                               // 64-bit form, small value
            len = 64'($urandom_range(0, 12));
        end
        if (len > {1'b0, cur_max}) len = {1'b0, cur_max};
        send_frame({fin_b, rsv1_b, 2'b00, op}, cur_role, enc, len, int'(len));
    endtask

    // Random frames up to a byte budget, sometimes pausing until all results are back.
    task automatic random_frames_until(input int budget);
        while (bytes_sent < budget) begin
            random_frame();
            if ($urandom_range(0, 7) == 0) wait_drained(0);
        end
    endtask

    // Closing case: one protocol error (latched, so only one per run) or an open giant frame.
    task automatic send_tail();
        logic [3:0]  op;
        logic [6:0]  code;
        logic [63:0] len;
        logic        fin_b, rsv1_b;
        case (tail_kind)
            ERR_RSV: begin
                push_byte({1'b1, 1'($urandom_range(0, 1)), 2'($urandom_range(1, 3)), OP_TEXT});
                push_byte({cur_role, 7'd3});
            end
            ERR_OPCODE: begin
                op = 4'($urandom_range(3, 7)) | ($urandom_range(0, 1) ? 4'h8 : 4'h0);
                push_byte({1'b1, 1'b0, 2'b00, op});
                push_byte(8'($urandom_range(0, 255)));
            end
            ERR_CONTROL: begin
                case ($urandom_range(0, 2))
                    0:       op = OP_CLOSE;
                    1:       op = OP_PING;
                    default: op = OP_PONG;
                endcase
                fin_b  = 1'b1;
                rsv1_b = 1'b0;
                code   = 7'($urandom_range(0, 125));
                case ($urandom_range(0, 2))
                    0:       fin_b = 1'b0;                       // fragmented control
                    1:       rsv1_b = 1'b1;                      // compressed control
                    default: code = $urandom_range(0, 1) ? LEN_CODE_16 : LEN_CODE_64;
                endcase
                push_byte({fin_b, rsv1_b, 2'b00, op});
                push_byte({cur_role, code});
            end
            ERR_LEN_MSB: begin
                len = {1'b1, 31'($urandom), 32'($urandom)};
                send_frame({1'b1, 1'b0, 2'b00, OP_BIN}, cur_role, ENC_64, len, 0);
            end
            ERR_MASKING: begin
                send_frame({1'b1, 1'b0, 2'b00, OP_BIN}, !cur_role, ENC_SHORT,
                           64'($urandom_range(0, 8)), 0);
            end
            ERR_SIZE: begin
                len = {1'b0, cur_max} + 64'($urandom_range(1, 200));
                send_frame({1'b1, 1'b0, 2'b00, OP_BIN}, cur_role, ENC_16, len, 0);
            end
            default: begin
                // huge 64-bit length, only the header and a few payload bytes go in
                len = {1'b0, 31'($urandom), 32'($urandom)} | 64'h1_0000_0000;
                send_frame({1'b1, 1'b0, 2'b00, OP_BIN}, cur_role, ENC_64, len, 24);
            end
        endcase
        // after an error every byte is dropped
        if (tail_kind != ERR_NONE)
            for (int i = 0; i < 16; i++) push_byte(8'($urandom_range(0, 255)));
    endtask

    initial begin
        aresetn   <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_addr  <= CFG_SERVER_ROLE;
        cfg_wdata <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cur_role = 1'b1;
        cur_max  = MAX_PAYLOAD_RST;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty masked control frame, 16-bit and 64-bit length forms
        send_frame({1'b1, 1'b0, 2'b00, OP_PONG}, 1'b1, ENC_SHORT, 64'd0, 0);
        send_frame({1'b0, 1'b1, 2'b00, OP_BIN}, 1'b1, ENC_16, 64'd2, 2);
        send_frame({1'b1, 1'b0, 2'b00, OP_CONT}, 1'b1, ENC_64, 64'd1, 1);

        // reset settings: server role, 16 MiB limit
        random_frames_until(200);

        // client role, unmasked frames, largest limit
        wait_drained(SETTLE_CYCLES);
        write_config(1'b0, {LEN_W{1'b1}});
        random_frames_until(330);

        // zero limit: only empty frames pass
        wait_drained(SETTLE_CYCLES);
        write_config(1'b1, '0);
        random_frames_until(400);

        // small limit, client role; frames are clamped to it
        wait_drained(SETTLE_CYCLES);
        write_config(1'b0, LEN_W'($urandom_range(5, 20)));
        random_frames_until(520);

        // last part: no idling, random role, then the closing case
        wait_drained(SETTLE_CYCLES);
        quiet     = 1'b1;
        tail_kind = 3'($urandom_range(0, 6));
        if (tail_kind == ERR_NONE)
            write_config(1'($urandom_range(0, 1)), {LEN_W{1'b1}});
        else
            write_config(1'($urandom_range(0, 1)), LEN_W'($urandom_range(8, 60)));
        random_frames_until(610);
        send_tail();

        wait_drained(SETTLE_CYCLES);
        $display("Sent %0d bytes in %0d frames over five register settings,",
                 bytes_sent, frames_sent);
        $display("%0d results checked.", results_checked);
        $display("Closing case: %0s (code %0d).",
                 tail_kind == ERR_NONE ? "open frame with 64-bit length" : "latched error",
                 tail_kind);
        if (mismatches == 0 && outstanding == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
